@@ hw/rtl/sbc_pkg.sv @@
// Shared types and constants of the scrolling banner compositor.
// Used by the divider, datapath, controller and top level; depends on nothing.
package sbc_pkg;

	localparam int DIV_W = 12;
	localparam int DVS_W = 11;
	localparam int CNT_W = 4;
	localparam int IDX_W = 18;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_DRAW = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic RK_PIXEL = 1'b0;
	localparam logic RK_TICK  = 1'b1;

	localparam logic [2:0] CFG_BAND_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_BAND_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_LEAD_OFFSET = 3'd2;
	localparam logic [2:0] CFG_CELL_ROWS   = 3'd3;
	localparam logic [2:0] CFG_FONT_BOOST  = 3'd4;

	localparam logic [10:0] MAX_BAND_WIDTH = 11'd1024;

	typedef struct packed {
		logic latch;
		logic div_start;
		logic div_sel;
		logic cap_mod;
		logic cap_addr;
		logic mem_rd;
		logic out_load;
	} sbc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sbc_sts_t;

endpackage

@@ hw/rtl/sbc_div.sv @@
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on sbc_pkg for its widths.
module sbc_div import sbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign done  = busy_q && (cnt_q == CNT_W'(DIV_W - 1));
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			if (fits) begin
				rem_q <= DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DVS_W-1:0];
			end
		end
	end

endmodule

@@ hw/rtl/sbc_datapath.sv @@
// Datapath: configuration registers, band store, phase and window counters,
// strip and band row arithmetic and the output register. Depends on sbc_pkg and sbc_div.
module sbc_datapath import sbc_pkg::*; #(
	parameter int BAND_WORDS = 32768,
	parameter int SET_COUNT  = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  sbc_cmd_t    cmd,
	output sbc_sts_t    sts,
	input  logic [1:0]  operation,
	input  logic [14:0] band_index,
	input  logic [7:0]  band_value,
	input  logic [5:0]  cell_row,
	input  logic [7:0]  cell_col,
	input  logic [15:0] screen_addr,
	input  logic [7:0]  background_pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [15:0] write_addr,
	output logic [7:0]  pixel_value,
	output logic [1:0]  next_set
);

	localparam int AW = $clog2(BAND_WORDS);
	localparam logic [IDX_W-1:0] BAND_LIMIT = IDX_W'(BAND_WORDS);
	localparam logic [2:0] SETS = 3'(SET_COUNT);

	logic [10:0] band_width_q;
	logic [5:0]  band_height_q;
	logic [9:0]  lead_offset_q;
	logic [5:0]  cell_rows_q;
	logic [7:0]  font_boost_q;

	logic [1:0]  phase_q;
	logic [10:0] window_q;

	logic [1:0]  op_q;
	logic [5:0]  row_q;
	logic [7:0]  col_q;
	logic [15:0] addr_q;
	logic [7:0]  bg_q;

	logic [10:0]      strip_q;
	logic [IDX_W-1:0] idx_q;
	logic             blank_q;
	logic             blank_s2;
	logic [7:0]       sample_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [15:0] waddr_q;
	logic [7:0]  pix_q;
	logic [1:0]  set_q;

	logic [7:0] mem [BAND_WORDS];

	logic [10:0]      w_eff;
	logic [5:0]       h_eff;
	logic [5:0]       rows_eff;
	logic [10:0]      lap;
	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;
	logic [IDX_W-1:0] wr_wide;
	logic [AW-1:0]    wr_addr;
	logic             load_we;
	logic [10:0]      band_col;
	logic [16:0]      row_base;
	logic [IDX_W-1:0] rd_idx;
	logic             rd_blank;
	logic [7:0]       font;
	logic [2:0]       phase_inc;
	logic [11:0]      window_inc;
	logic [1:0]       phase_nxt;
	logic [10:0]      window_nxt;

	always_comb begin
		if (band_width_q == 11'd0) begin
			w_eff = 11'd1;
		end else if (band_width_q > MAX_BAND_WIDTH) begin
			w_eff = MAX_BAND_WIDTH;
		end else begin
			w_eff = band_width_q;
		end
		h_eff    = (band_height_q == 6'd0) ? 6'd1 : band_height_q;
		rows_eff = (cell_rows_q == 6'd0) ? 6'd1 : cell_rows_q;
	end

	assign lap = w_eff + {1'b0, lead_offset_q};

	always_comb begin
		if (cmd.div_sel) begin
			div_dividend = {6'b0, row_q} * {6'b0, h_eff};
			div_divisor  = {5'b0, rows_eff};
		end else begin
			div_dividend = {4'b0, col_q} + {1'b0, window_q};
			div_divisor  = lap;
		end
	end

	sbc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_width_q  <= 11'd640;
			band_height_q <= 6'd32;
			lead_offset_q <= 10'd104;
			cell_rows_q   <= 6'd31;
			font_boost_q  <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BAND_WIDTH:  band_width_q  <= cfg_data;
				CFG_BAND_HEIGHT: band_height_q <= cfg_data[5:0];
				CFG_LEAD_OFFSET: lead_offset_q <= cfg_data[9:0];
				CFG_CELL_ROWS:   cell_rows_q   <= cfg_data[5:0];
				CFG_FONT_BOOST:  font_boost_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign wr_wide = {3'b0, band_index};
	assign wr_addr = wr_wide[AW-1:0];
	assign load_we = cmd.latch && (operation == OP_LOAD) && (wr_wide < BAND_LIMIT);

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[wr_addr] <= band_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			sample_q <= mem[idx_q[AW-1:0]];
			blank_s2 <= blank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= operation;
			row_q  <= cell_row;
			col_q  <= cell_col;
			addr_q <= screen_addr;
			bg_q   <= background_pixel;
		end
		if (cmd.cap_mod) begin
			strip_q <= div_rem;
		end
		if (cmd.cap_addr) begin
			idx_q   <= rd_idx;
			blank_q <= rd_blank;
		end
	end

	assign band_col = strip_q - {1'b0, lead_offset_q};
	assign row_base = {11'b0, div_quo[5:0]} * {6'b0, w_eff};
	assign rd_idx   = {1'b0, row_base} + {7'b0, band_col};
	assign rd_blank = (strip_q < {1'b0, lead_offset_q}) || (div_quo >= {6'b0, h_eff}) ||
		(rd_idx >= BAND_LIMIT);

	assign font = (blank_s2 || (sample_q == 8'd0)) ? 8'd0 : font_boost_q + sample_q;

	always_comb begin
		phase_inc  = {1'b0, phase_q} + 3'd1;
		window_inc = {1'b0, window_q} + 12'd1;
		phase_nxt  = phase_inc[1:0];
		window_nxt = window_q;
		if (phase_inc >= SETS) begin
			phase_nxt = 2'd0;
			if (window_inc >= {1'b0, lap}) begin
				window_nxt = 11'd0;
			end else begin
				window_nxt = window_inc[10:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 2'd0;
			window_q    <= 11'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (op_q == OP_TICK) begin
					phase_q  <= phase_nxt;
					window_q <= window_nxt;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (op_q == OP_TICK) begin
				kind_q  <= RK_TICK;
				waddr_q <= 16'd0;
				pix_q   <= 8'd0;
				set_q   <= phase_nxt;
			end else begin
				kind_q  <= RK_PIXEL;
				waddr_q <= addr_q;
				pix_q   <= bg_q + font;
				set_q   <= phase_q;
			end
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign write_addr  = waddr_q;
	assign pixel_value = pix_q;
	assign next_set    = set_q;

`ifndef ASSERT_OFF
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, phase_q} < SETS)
		else $error("phase has left the range of scatter sets");
	a_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == RK_TICK) |-> (waddr_q == 16'd0) && (pix_q == 8'd0))
		else $error("tick beat carries a nonzero address or pixel");
	a_pixel_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == RK_PIXEL) |-> (set_q == phase_q))
		else $error("pixel beat reports a set other than the current phase");
`endif

endmodule

@@ hw/rtl/sbc_ctrl.sv @@
// Controller state machine that sequences the datapath for each accepted item.
// Depends on sbc_pkg for the command and status types and operation codes.
module sbc_ctrl import sbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  sbc_sts_t   sts,
	output sbc_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MSTART = 3'd1;
	localparam logic [2:0] S_MWAIT  = 3'd2;
	localparam logic [2:0] S_RSTART = 3'd3;
	localparam logic [2:0] S_RWAIT  = 3'd4;
	localparam logic [2:0] S_ADDR   = 3'd5;
	localparam logic [2:0] S_READ   = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       fire;

	assign in_ready = (state_q == S_IDLE);
	assign fire     = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.latch = fire;
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					priority if (operation == OP_DRAW) begin
						state_nxt = S_MSTART;
					end else if (operation == OP_TICK) begin
						state_nxt = S_FIN;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_MSTART: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_MWAIT;
			end
			S_MWAIT: begin
				if (sts.div_done) begin
					state_nxt = S_RSTART;
				end
			end
			S_RSTART: begin
				cmd.cap_mod   = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_nxt     = S_RWAIT;
			end
			S_RWAIT: begin
				cmd.div_sel = 1'b1;
				if (sts.div_done) begin
					state_nxt = S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.cap_addr = 1'b1;
				state_nxt    = S_READ;
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				state_nxt  = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ((operation == OP_DRAW) || (operation == OP_TICK)) |=> !in_ready)
		else $error("a second item was taken while one was still in work");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register loaded while a beat still waits");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !in_ready && !cmd.out_load)
		else $error("divider started outside a draw");
`endif

endmodule

@@ hw/rtl/scrolling_banner_compositor.sv @@
// Draw item: the shared restoring divider runs twice (strip modulo, then band row),
// 12 quotient bits each, followed by the address, band store read and finish states.
// End of tick: goes straight to the finish state. Load: written on acceptance.
// A new item is taken only once the last one has been loaded into the output register.
// Asynchronous active-low reset restores the configuration registers to their defaults and clears
// phase and window; the band store is not cleared and holds nothing until loaded.
module scrolling_banner_compositor import sbc_pkg::*; #(
	parameter int BAND_WORDS = 32768,
	parameter int SET_COUNT  = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [14:0] band_index,
	input  logic [7:0]  band_value,
	input  logic [5:0]  cell_row,
	input  logic [7:0]  cell_col,
	input  logic [15:0] screen_addr,
	input  logic [7:0]  background_pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [15:0] write_addr,
	output logic [7:0]  pixel_value,
	output logic [1:0]  next_set
);

	sbc_cmd_t cmd;
	sbc_sts_t sts;

	assign cfg_ready = 1'b1;

	sbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbc_datapath #(
		.BAND_WORDS (BAND_WORDS),
		.SET_COUNT  (SET_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.sts              (sts),
		.operation        (operation),
		.band_index       (band_index),
		.band_value       (band_value),
		.cell_row         (cell_row),
		.cell_col         (cell_col),
		.screen_addr      (screen_addr),
		.background_pixel (background_pixel),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.write_addr       (write_addr),
		.pixel_value      (pixel_value),
		.next_set         (next_set)
	);

endmodule
